// File: src/xpr_pkg.sv
// xpr_pkg: shared types and codes of the xor parity packet recovery block
// no dependencies

package xpr_pkg;

  typedef enum logic [2:0] {
    CMD_DATA    = 3'd0,
    CMD_PARITY  = 3'd1,
    CMD_QUERY   = 3'd2,
    CMD_RECOVER = 3'd3,
    CMD_REMOVE  = 3'd4
  } xpr_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_NOREC = 2'd2
  } xpr_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_EXEC,
    S_RESP,
    S_REC_PAR,
    S_REC_PKT,
    S_REC_FIN,
    S_REC_OUT
  } xpr_state_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] blk_id;
    logic [2:0] pkt_idx;
    logic [7:0] data_byte;
    logic       byte_last;
    logic [3:0] packet_total;
  } xpr_in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       recoverable;
    logic [7:0] out_byte;
    logic [2:0] out_index;
    logic       out_last;
  } xpr_out_item_t;

  // verdict of the recoverability check
  typedef struct packed {
    logic       ok;
    logic       miss_valid;
    logic [2:0] miss_idx;
  } xpr_chk_t;

endpackage

// File: src/xpr_if.sv
// xpr_in_if / xpr_out_if: valid/ready channels carrying one item per transfer
// depends on xpr_pkg

interface xpr_in_if;
  logic                 valid;
  logic                 ready;
  xpr_pkg::xpr_in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface xpr_out_if;
  logic                  valid;
  logic                  ready;
  xpr_pkg::xpr_out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/xpr_ram.sv
// xpr_ram: generic single write, single read ram with registered read
// no dependencies

module xpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/xpr_check.sv
// xpr_check: decides whether a slot is complete or has one recoverable gap
// depends on xpr_pkg

module xpr_check #(
  parameter int PACKETS = 8
) (
  input  logic [PACKETS-1:0] bitmap,
  input  logic [3:0]         cnt,
  input  logic               seen,
  output xpr_pkg::xpr_chk_t  chk
);
  import xpr_pkg::*;

  logic [PACKETS-1:0] have;
  logic [PACKETS-1:0] gap;
  logic [3:0]         rc;
  logic [3:0]         gc;
  logic [2:0]         miss;
  logic               complete;
  logic               one_gap;

  always_comb begin
    rc   = '0;
    gc   = '0;
    miss = '0;
    for (int k = 0; k < PACKETS; k++) begin
      have[k] = bitmap[k] && (4'(k) < cnt);
      gap[k]  = !bitmap[k] && (4'(k) < cnt);
      rc      = rc + 4'(have[k]);
      gc      = gc + 4'(gap[k]);
      if (gap[k]) begin
        miss = 3'(k);
      end
    end
    complete       = (rc == cnt);
    one_gap        = ((rc + 4'd1) == cnt) && seen && (gc == 4'd1);
    chk.ok         = complete || one_gap;
    chk.miss_valid = !complete && one_gap;
    chk.miss_idx   = miss;
  end
endmodule

// File: src/xor_parity_packet_recovery.sv
// single-result commands: slot search, execute and respond, result registered
// recover: per output byte a parity read, then one stored packet read per cycle
// the block takes one item at a time, ready only while idle
// synchronous active-low reset clears slot table, position counter and control;
// stored bytes and packet lengths are not cleared
// top level; depends on xpr_pkg, xpr_if, xpr_ram, xpr_check

module xor_parity_packet_recovery #(
  parameter int SLOTS   = 4,
  parameter int PACKETS = 8,
  parameter int PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  xpr_in_if.sink     in_ch,
  xpr_out_if.source  out_ch
);
  import xpr_pkg::*;

  localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW        = $clog2(PACKETS);
  localparam int PW        = $clog2(PAYLOAD + 1);
  localparam int PKT_DEPTH = SLOTS * PACKETS * PAYLOAD;
  localparam int PAR_DEPTH = SLOTS * PAYLOAD;
  localparam int LEN_DEPTH = SLOTS * PACKETS;
  localparam int PKT_AW    = (PKT_DEPTH > 1) ? $clog2(PKT_DEPTH) : 1;
  localparam int PAR_AW    = (PAR_DEPTH > 1) ? $clog2(PAR_DEPTH) : 1;
  localparam int LEN_AW    = (LEN_DEPTH > 1) ? $clog2(LEN_DEPTH) : 1;

  // slot table
  logic               act_r  [SLOTS];
  logic [7:0]         bid_r  [SLOTS];
  logic [PACKETS-1:0] bmp_r  [SLOTS];
  logic               seen_r [SLOTS];
  logic [3:0]         cnt_r  [SLOTS];
  logic [PW-1:0]      plen_r [SLOTS];

  // sequencer
  xpr_state_t    state_r, state_nxt;
  xpr_in_item_t  item_r, item_nxt;
  logic [SW-1:0] sidx_r, sidx_nxt;
  logic          hit_r, hit_nxt;
  logic [SW-1:0] hslot_r, hslot_nxt;
  logic          free_r, free_nxt;
  logic [SW-1:0] fslot_r, fslot_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  xpr_out_item_t res_r, res_nxt;
  xpr_out_item_t out_r, out_nxt;
  logic          ov_r, ov_nxt;

  // recovery loop
  logic [PW-1:0] n_r, n_nxt;
  logic [PW-1:0] j_r, j_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [2:0]    miss_r, miss_nxt;
  logic          first_r, first_nxt;
  logic          take_r, take_nxt;
  logic [7:0]    acc_r, acc_nxt;

  logic          out_free;
  logic [SW-1:0] wslot;
  logic          is_wr;
  logic          bad_idx;
  logic          wr_ok;
  logic          pos_lt;
  logic [PW-1:0] wlen;
  xpr_chk_t      chk;

  logic [7:0]    pkt_rdata;
  logic [7:0]    par_rdata;
  logic [PW-1:0] len_rdata;
  logic          pkt_we, par_we, len_we;
  logic [PKT_AW-1:0] pkt_waddr, pkt_raddr;
  logic [PAR_AW-1:0] par_waddr, par_raddr;
  logic [LEN_AW-1:0] len_waddr, len_raddr;

  xpr_check #(.PACKETS(PACKETS)) u_check (
    .bitmap (bmp_r[hslot_r]),
    .cnt    (cnt_r[hslot_r]),
    .seen   (seen_r[hslot_r]),
    .chk    (chk)
  );

  // write side decode, valid in the execute step
  always_comb begin
    wslot   = hit_r ? hslot_r : fslot_r;
    is_wr   = (item_r.command == CMD_DATA) || (item_r.command == CMD_PARITY);
    bad_idx = (item_r.command == CMD_DATA) && ({1'b0, item_r.pkt_idx} >= 4'(PACKETS));
    wr_ok   = is_wr && !bad_idx && (hit_r || free_r);
    pos_lt  = pos_r < PW'(PAYLOAD);
    wlen    = pos_lt ? pos_r + PW'(1) : PW'(PAYLOAD);
  end

  // memory ports: writes during execute, reads during recovery
  always_comb begin
    pkt_we    = (state_r == S_EXEC) && wr_ok && (item_r.command == CMD_DATA) && pos_lt;
    par_we    = (state_r == S_EXEC) && wr_ok && (item_r.command == CMD_PARITY) && pos_lt;
    len_we    = (state_r == S_EXEC) && wr_ok && (item_r.command == CMD_DATA)
                && item_r.byte_last;
    pkt_waddr = PKT_AW'((int'(wslot) * PACKETS + int'(item_r.pkt_idx)) * PAYLOAD
                        + int'(pos_r));
    par_waddr = PAR_AW'(int'(wslot) * PAYLOAD + int'(pos_r));
    len_waddr = LEN_AW'(int'(wslot) * PACKETS + int'(item_r.pkt_idx));
    pkt_raddr = PKT_AW'((int'(hslot_r) * PACKETS + int'(i_r)) * PAYLOAD + int'(j_r));
    par_raddr = PAR_AW'(int'(hslot_r) * PAYLOAD + int'(j_r));
    len_raddr = LEN_AW'(int'(hslot_r) * PACKETS + int'(i_r));
  end

  xpr_ram #(.WIDTH(8), .DEPTH(PKT_DEPTH)) u_pkt_ram (
    .clk   (clk),
    .we    (pkt_we),
    .waddr (pkt_waddr),
    .wdata (item_r.data_byte),
    .raddr (pkt_raddr),
    .rdata (pkt_rdata)
  );

  xpr_ram #(.WIDTH(8), .DEPTH(PAR_DEPTH)) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (item_r.data_byte),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  xpr_ram #(.WIDTH(PW), .DEPTH(LEN_DEPTH)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (wlen),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = out_r;
  assign out_free     = !ov_r || out_ch.ready;

  // next state and datapath control
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    sidx_nxt  = sidx_r;
    hit_nxt   = hit_r;
    hslot_nxt = hslot_r;
    free_nxt  = free_r;
    fslot_nxt = fslot_r;
    pos_nxt   = pos_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    ov_nxt    = ov_r && !out_ch.ready;
    n_nxt     = n_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    miss_nxt  = miss_r;
    first_nxt = first_r;
    take_nxt  = take_r;
    acc_nxt   = acc_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt  = in_ch.data;
          sidx_nxt  = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_SEARCH;
        end
      end

      // one slot compared per cycle: first match and lowest free slot
      S_SEARCH: begin
        if (!hit_r && act_r[sidx_r] && (bid_r[sidx_r] == item_r.blk_id)) begin
          hit_nxt   = 1'b1;
          hslot_nxt = sidx_r;
        end
        if (!free_r && !act_r[sidx_r]) begin
          free_nxt  = 1'b1;
          fslot_nxt = sidx_r;
        end
        if (sidx_r == SW'(SLOTS - 1)) begin
          state_nxt = S_EXEC;
        end else begin
          sidx_nxt = sidx_r + SW'(1);
        end
      end

      S_EXEC: begin
        res_nxt.status      = ST_OK;
        res_nxt.recoverable = 1'b0;
        res_nxt.out_byte    = '0;
        res_nxt.out_index   = '0;
        res_nxt.out_last    = 1'b1;
        state_nxt           = S_RESP;
        case (item_r.command)
          CMD_DATA, CMD_PARITY: begin
            if (!wr_ok) begin
              res_nxt.status = ST_ERR;
              if (item_r.byte_last) begin
                pos_nxt = '0;
              end
            end else if (item_r.byte_last) begin
              pos_nxt = '0;
            end else begin
              pos_nxt = wlen;
            end
          end
          CMD_QUERY: begin
            if (!hit_r) begin
              res_nxt.status = ST_ERR;
            end else begin
              res_nxt.recoverable = chk.ok;
            end
          end
          CMD_RECOVER: begin
            miss_nxt = chk.miss_idx;
            if (!hit_r) begin
              res_nxt.status = ST_ERR;
            end else if (!(chk.ok && chk.miss_valid)) begin
              res_nxt.status = ST_NOREC;
            end else if (plen_r[hslot_r] == '0) begin
              res_nxt.out_index = chk.miss_idx;
            end else begin
              n_nxt     = plen_r[hslot_r];
              j_nxt     = '0;
              state_nxt = S_REC_PAR;
            end
          end
          CMD_REMOVE: begin
            if (!hit_r) begin
              res_nxt.status = ST_ERR;
            end
          end
          default: begin
            res_nxt.status = ST_ERR;
          end
        endcase
      end

      S_RESP: begin
        if (out_free) begin
          out_nxt   = res_r;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      // parity byte read issued, packets follow
      S_REC_PAR: begin
        i_nxt     = '0;
        first_nxt = 1'b1;
        state_nxt = S_REC_PKT;
      end

      // issue packet i, fold in the data read the cycle before
      S_REC_PKT: begin
        first_nxt = 1'b0;
        if (first_r) begin
          acc_nxt = par_rdata;
        end else if (take_r && (j_r < len_rdata)) begin
          acc_nxt = acc_r ^ pkt_rdata;
        end
        take_nxt = (4'(i_r) < cnt_r[hslot_r]) && (3'(i_r) != miss_r);
        if (i_r == IW'(PACKETS - 1)) begin
          state_nxt = S_REC_FIN;
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end

      S_REC_FIN: begin
        if (take_r && (j_r < len_rdata)) begin
          acc_nxt = acc_r ^ pkt_rdata;
        end
        state_nxt = S_REC_OUT;
      end

      S_REC_OUT: begin
        if (out_free) begin
          out_nxt.status      = ST_OK;
          out_nxt.recoverable = 1'b0;
          out_nxt.out_byte    = acc_r;
          out_nxt.out_index   = miss_r;
          out_nxt.out_last    = ((j_r + PW'(1)) == n_r);
          ov_nxt              = 1'b1;
          if ((j_r + PW'(1)) == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + PW'(1);
            state_nxt = S_REC_PAR;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      pos_r   <= '0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
      sidx_r  <= '0;
      i_r     <= '0;
      j_r     <= '0;
      first_r <= 1'b0;
      take_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      pos_r   <= pos_nxt;
      hit_r   <= hit_nxt;
      free_r  <= free_nxt;
      sidx_r  <= sidx_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      first_r <= first_nxt;
      take_r  <= take_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    hslot_r <= hslot_nxt;
    fslot_r <= fslot_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
    n_r     <= n_nxt;
    miss_r  <= miss_nxt;
    acc_r   <= acc_nxt;
  end

  // slot table updates, all in the execute step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        act_r[s]  <= 1'b0;
        bid_r[s]  <= '0;
        bmp_r[s]  <= '0;
        seen_r[s] <= 1'b0;
        cnt_r[s]  <= '0;
        plen_r[s] <= '0;
      end
    end else if (state_r == S_EXEC) begin
      if (wr_ok) begin
        // a new slot starts with empty bitmap and no parity; count is kept
        if (!hit_r) begin
          act_r[wslot]  <= 1'b1;
          bid_r[wslot]  <= item_r.blk_id;
          bmp_r[wslot]  <= '0;
          seen_r[wslot] <= 1'b0;
        end
        if (item_r.byte_last) begin
          if (item_r.command == CMD_DATA) begin
            bmp_r[wslot] <= (hit_r ? bmp_r[wslot] : '0)
                            | (PACKETS'(1) << item_r.pkt_idx);
            if (({1'b0, item_r.pkt_idx} + 4'd1) > cnt_r[wslot]) begin
              cnt_r[wslot] <= {1'b0, item_r.pkt_idx} + 4'd1;
            end
          end else begin
            plen_r[wslot] <= wlen;
            seen_r[wslot] <= 1'b1;
            cnt_r[wslot]  <= item_r.packet_total;
          end
        end
      end
      if ((item_r.command == CMD_REMOVE) && hit_r) begin
        act_r[hslot_r]  <= 1'b0;
        bid_r[hslot_r]  <= '0;
        bmp_r[hslot_r]  <= '0;
        seen_r[hslot_r] <= 1'b0;
        cnt_r[hslot_r]  <= '0;
        plen_r[hslot_r] <= '0;
      end
    end
  end
endmodule

// File: test/tb_xpr_scoreboard.sv
// xpr_fec_predictor: predicts and checks the results of the xor parity recovery block
// depends on xpr_pkg

class xpr_fec_predictor;
  localparam int NSLOT = 4;
  localparam int NPKT  = 8;
  localparam int PLD   = 64;

  bit        act     [NSLOT];
  bit [7:0]  bid     [NSLOT];
  bit [7:0]  bmap    [NSLOT];
  bit        par_seen[NSLOT];
  bit [3:0]  pcount  [NSLOT];
  bit [7:0]  pbytes  [NSLOT][NPKT][PLD];
  bit [6:0]  plen    [NSLOT][NPKT];
  bit [7:0]  parb    [NSLOT][PLD];
  bit [6:0]  parlen  [NSLOT];
  int unsigned wpos;
  xpr_pkg::xpr_out_item_t pending[$];
  int errors;

  function int lookup(bit [7:0] id);
    for (int i = 0; i < NSLOT; i++) if (act[i] && bid[i] == id) return i;
    return -1;
  endfunction

  function int claim(bit [7:0] id);
    int s;
    s = lookup(id);
    if (s >= 0) return s;
    for (int i = 0; i < NSLOT; i++)
      if (!act[i]) begin
        act[i] = 1; bid[i] = id; bmap[i] = 0; par_seen[i] = 0;
        return i;
      end
    return -1;
  endfunction

  function void push(bit [1:0] st, bit rec, bit [7:0] b, bit [2:0] ix, bit lst);
    xpr_pkg::xpr_out_item_t r;
    r.status = st; r.recoverable = rec; r.out_byte = b; r.out_index = ix; r.out_last = lst;
    pending.push_back(r);
  endfunction

  // ok flag; miss gets the lost index or -1
  function bit assess(int s, output int miss);
    int cnt, rc, gc;
    bit [7:0] mask, have, gap;
    cnt = pcount[s];
    mask = (cnt >= NPKT) ? 8'hff : 8'((1 << cnt) - 1);
    have = bmap[s] & mask;
    gap = ~have & mask;
    rc = $countones(have);
    gc = $countones(gap);
    miss = -1;
    if (rc == cnt) return 1;
    if (rc + 1 == cnt && par_seen[s] && gc == 1) begin
      for (int i = 0; i < NPKT; i++) if (gap[i]) miss = i;
      return 1;
    end
    return 0;
  endfunction

  function void note_input(xpr_pkg::xpr_in_item_t it);
    int s, miss, n, len;
    bit [7:0] v;
    bit ok;
    case (it.command)
      xpr_pkg::CMD_DATA, xpr_pkg::CMD_PARITY: begin
        s = (it.command == xpr_pkg::CMD_DATA && it.pkt_idx >= NPKT) ? -1
            : claim(it.blk_id);
        if (s < 0) begin
          if (it.byte_last) wpos = 0;
          push(xpr_pkg::ST_ERR, 0, 0, 0, 1);
        end else begin
          if (wpos < PLD) begin
            if (it.command == xpr_pkg::CMD_DATA) pbytes[s][it.pkt_idx][wpos] = it.data_byte;
            else parb[s][wpos] = it.data_byte;
          end
          len = (wpos < PLD) ? wpos + 1 : PLD;
          if (it.byte_last) begin
            if (it.command == xpr_pkg::CMD_DATA) begin
              plen[s][it.pkt_idx] = 7'(len);
              bmap[s][it.pkt_idx] = 1;
              if (it.pkt_idx + 1 > pcount[s]) pcount[s] = 4'(it.pkt_idx + 1);
            end else begin
              parlen[s] = 7'(len); par_seen[s] = 1; pcount[s] = it.packet_total;
            end
            wpos = 0;
          end else wpos = len;
          push(xpr_pkg::ST_OK, 0, 0, 0, 1);
        end
      end
      xpr_pkg::CMD_QUERY: begin
        s = lookup(it.blk_id);
        if (s < 0) push(xpr_pkg::ST_ERR, 0, 0, 0, 1);
        else begin
          ok = assess(s, miss);
          push(xpr_pkg::ST_OK, ok, 0, 0, 1);
        end
      end
      xpr_pkg::CMD_RECOVER: begin
        s = lookup(it.blk_id);
        if (s < 0) push(xpr_pkg::ST_ERR, 0, 0, 0, 1);
        else begin
          ok = assess(s, miss);
          if (!ok || miss < 0) push(xpr_pkg::ST_NOREC, 0, 0, 0, 1);
          else begin
            n = (parlen[s] > PLD) ? PLD : parlen[s];
            if (n == 0) push(xpr_pkg::ST_OK, 0, 0, 3'(miss), 1);
            for (int j = 0; j < n; j++) begin
              v = parb[s][j];
              for (int i = 0; i < NPKT && i < pcount[s]; i++)
                if (i != miss && j < plen[s][i]) v ^= pbytes[s][i][j];
              push(xpr_pkg::ST_OK, 0, v, 3'(miss), j + 1 == n);
            end
          end
        end
      end
      xpr_pkg::CMD_REMOVE: begin
        s = lookup(it.blk_id);
        if (s < 0) push(xpr_pkg::ST_ERR, 0, 0, 0, 1);
        else begin
          act[s] = 0; bid[s] = 0; bmap[s] = 0; par_seen[s] = 0; pcount[s] = 0; parlen[s] = 0;
          push(xpr_pkg::ST_OK, 0, 0, 0, 1);
        end
      end
      default: push(xpr_pkg::ST_ERR, 0, 0, 0, 1);
    endcase
  endfunction

  function void check_result(xpr_pkg::xpr_out_item_t got);
    xpr_pkg::xpr_out_item_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.status !== exp_r.status)
      $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
    if (got.recoverable !== exp_r.recoverable)
      $display("%0t: recoverable expected %0d actual %0d", $time, exp_r.recoverable,
               got.recoverable);
    if (got.out_byte !== exp_r.out_byte)
      $display("%0t: out_byte expected %h actual %h", $time, exp_r.out_byte, got.out_byte);
    if (got.out_index !== exp_r.out_index)
      $display("%0t: out_index expected %0d actual %0d", $time, exp_r.out_index, got.out_index);
    if (got.out_last !== exp_r.out_last)
      $display("%0t: out_last expected %0d actual %0d", $time, exp_r.out_last, got.out_last);
    if (got !== exp_r) errors++;
  endfunction
endclass

// File: test/tb.sv
// tb: self-checking bench for xor_parity_packet_recovery, random idling on both channels
// depends on xpr_pkg, xpr_if, the block's rtl and tb_xpr_scoreboard

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xpr_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  xpr_in_if  in_ch();
  xpr_out_if out_ch();

  xor_parity_packet_recovery dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  xpr_fec_predictor fec = new();
  bit quiet_phase;   // no idling while set
  int stall_cycles;
  int sent;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  // sink: random back-pressure, checks at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) fec.check_result(out_ch.data);
  end
  always @(negedge clk) begin
    out_ch.ready <= rst_n && (quiet_phase || $urandom_range(99) >= 31);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one transfer into the block, random gap first unless in the quiet phase
  task automatic send(xpr_in_item_t it);
    while (!quiet_phase && $urandom_range(99) < 31) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.data <= it;
    in_ch.valid <= 1;
    do @(posedge clk); while (!in_ch.ready);
    fec.note_input(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_cmd(xpr_cmd_t c, bit [7:0] id, bit [2:0] ix = 0, bit [7:0] b = 0,
                          bit lst = 0, bit [3:0] tot = 0);
    xpr_in_item_t it;
    it.command = c; it.blk_id = id; it.pkt_idx = ix;
    it.data_byte = b; it.byte_last = lst; it.packet_total = tot;
    send(it);
  endtask

  // one whole packet, bytes in order, so no unwritten byte is ever read back
  task automatic send_packet(bit par, bit [7:0] id, bit [2:0] ix, int len, bit [3:0] tot);
    for (int k = 0; k < len; k++)
      send_cmd(par ? CMD_PARITY : CMD_DATA, id, ix, 8'($urandom_range(255)), k == len - 1,
               tot);
  endtask

  // a well-formed block with one packet possibly dropped, then query, recover and sometimes remove
  task automatic send_block(bit [7:0] id, bit small_sizes);
    int npk, drop, len;
    npk = $urandom_range(2, 8);
    drop = $urandom_range(npk);   // npk means nothing dropped
    for (int i = 0; i < npk; i++) begin
      len = small_sizes ? $urandom_range(1, 4) : $urandom_range(1, 70);
      if (i != drop) send_packet(0, id, 3'(i), len, 0);
    end
    if ($urandom_range(9) != 0) send_packet(1, id, 0, $urandom_range(1, 5), 4'(npk));
    send_cmd(CMD_QUERY, id);
    send_cmd(CMD_RECOVER, id);
    if ($urandom_range(3) != 0) send_cmd(CMD_REMOVE, id);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 0;
    while (fec.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_noise();
    xpr_in_item_t it;
    it = xpr_in_item_t'($bits(xpr_in_item_t)'($urandom));
    // a data or parity byte here always ends its packet
    if (it.command <= CMD_PARITY) it.byte_last = 1;
    send(it);
  endtask

  initial begin
    quiet_phase = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: unknown block, data for packet index 7, unused commands, recovery of a lost packet
    send_cmd(CMD_QUERY, 8'hff);
    send_cmd(CMD_RECOVER, 8'h00);
    send_cmd(CMD_REMOVE, 8'h12);
    send_cmd(CMD_DATA, 8'h01, 3'd7, 8'hff, 1);
    send_cmd(xpr_cmd_t'(3'd7), 8'h01);
    send_cmd(xpr_cmd_t'(3'd5), 8'h01);
    send_packet(0, 8'h00, 0, 2, 0);
    send_packet(0, 8'h00, 2, 1, 0);
    send_packet(1, 8'h00, 0, 3, 4'd3);
    send_cmd(CMD_QUERY, 8'h00);
    send_cmd(CMD_RECOVER, 8'h00);
    // complete block: nothing missing
    send_packet(0, 8'h00, 1, 1, 0);
    send_cmd(CMD_RECOVER, 8'h00);
    // packet_total above the table size, not recoverable
    send_packet(1, 8'hff, 0, 1, 4'd15);
    send_cmd(CMD_RECOVER, 8'hff);
    // fill all slots, then no free slot
    send_packet(0, 8'h20, 7, 1, 0);
    send_packet(0, 8'h21, 0, 1, 0);
    send_cmd(CMD_DATA, 8'h22, 0, 8'h00, 1);
    send_cmd(CMD_REMOVE, 8'h00);
    send_cmd(CMD_REMOVE, 8'hff);
    send_cmd(CMD_REMOVE, 8'h20);
    send_cmd(CMD_REMOVE, 8'h21);

    // sender holds off until everything has drained
    wait_drained();

    // long stretch without idling, small packets
    quiet_phase = 1;
    for (int b = 0; b < 4; b++) send_block(8'($urandom_range(255)), 1);
    quiet_phase = 0;

    // one block with packets of up to 70 bytes, longer ones truncated at the payload size
    send_block(8'h5a, 0);

    while (sent < 350) begin
      if ($urandom_range(4) == 0) send_noise();
      else send_block(8'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(3)),
                      1);
    end

    wait_drained();
    if (fec.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// File: filelist.f
src/xpr_pkg.sv
src/xpr_if.sv
src/xpr_ram.sv
src/xpr_check.sv
src/xor_parity_packet_recovery.sv
test/tb_xpr_scoreboard.sv
test/tb.sv
